// ----- sv/mvr_pkg.sv -----
// shared constants and types of the master volume ramp output stage
package mvr_pkg;

    // frame length in samples
    localparam int FRAME_SAMPLES = 96;

    // volume and sample widths
    localparam int VOL_W    = 16;
    localparam int SAMPLE_W = 32;
    localparam int OUT_W    = 16;
    localparam int POS_W    = $clog2(FRAME_SAMPLES);

    // ramp numerator, at most FRAME_SAMPLES * 65535
    localparam int NUM_W = $clog2(FRAME_SAMPLES * 65535 + 1);

    // exact floor division by the frame length through a reciprocal multiply
    localparam int      DIV_SHIFT  = NUM_W + $clog2(FRAME_SAMPLES);
    localparam longint  DIV_MULT   = ((64'd1 << DIV_SHIFT) + FRAME_SAMPLES - 1) / FRAME_SAMPLES;
    localparam int      DIV_MULT_W = $clog2(DIV_MULT + 1);
    localparam int      DIV_PROD_W = NUM_W + DIV_MULT_W;

    // gain scaling and output limits
    localparam int GAIN_SHIFT = 15;
    localparam int SCALE_W    = SAMPLE_W + VOL_W + 1;
    localparam logic [VOL_W-1:0] VOL_RESET = 16'h8000;
    localparam logic signed [SAMPLE_W-1:0] SAT_MAX = 32'sd32767;
    localparam logic signed [SAMPLE_W-1:0] SAT_MIN = -32'sd32767;

    // pipeline control shared by the gain unit and the lanes
    typedef struct packed {
        logic adv;   // whole pipeline moves one stage
        logic take;  // an input word is accepted
    } pipe_ctl_t;

endpackage

// ----- sv/mvr_gain.sv -----
// ramp position counter and gain computation for one stereo word
module mvr_gain
    import mvr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  pipe_ctl_t        ctl,
    input  logic [VOL_W-1:0] target_volume,
    output logic             item_last,
    output logic [VOL_W-1:0] gain
);

    logic [VOL_W-1:0]      start_reg, start_next;
    logic [VOL_W-1:0]      end_reg, end_next;
    logic [NUM_W-1:0]      num_reg, num_next;
    logic [POS_W-1:0]      pos_reg, pos_next;
    logic [NUM_W-1:0]      n1_reg;
    logic [DIV_PROD_W-1:0] prod_reg;
    logic [POS_W-1:0]      pos_eff;
    logic                  first;

    // position in the frame, an out of range count starts a new frame
    always_comb
    begin
        if ({1'b0, pos_reg} >= (POS_W+1)'(FRAME_SAMPLES))
        begin
            pos_eff = '0;
        end
        else
        begin
            pos_eff = pos_reg;
        end
        first     = (pos_eff == '0);
        item_last = (pos_eff == POS_W'(FRAME_SAMPLES - 1));
    end

    // ramp end points and running numerator
    always_comb
    begin
        start_next = start_reg;
        end_next   = end_reg;
        num_next   = num_reg;
        pos_next   = pos_reg;
        if (ctl.take)
        begin
            if (first)
            begin
                start_next = end_reg;
                end_next   = target_volume;
                num_next   = NUM_W'(FRAME_SAMPLES - 1) * NUM_W'(end_reg)
                           + NUM_W'(target_volume);
            end
            else
            begin
                num_next = num_reg + NUM_W'(end_reg) - NUM_W'(start_reg);
            end
            if (item_last)
            begin
                pos_next = '0;
            end
            else
            begin
                pos_next = pos_eff + POS_W'(1);
            end
        end
    end

    // ramp state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= VOL_RESET;
            end_reg   <= VOL_RESET;
            num_reg   <= '0;
            pos_reg   <= '0;
        end
        else
        begin
            start_reg <= start_next;
            end_reg   <= end_next;
            num_reg   <= num_next;
            pos_reg   <= pos_next;
        end
    end

    // numerator then reciprocal product
    always_ff @(posedge clk)
    begin
        if (ctl.adv)
        begin
            n1_reg   <= num_next;
            prod_reg <= DIV_PROD_W'(n1_reg) * DIV_PROD_W'(DIV_MULT);
        end
    end

    // quotient by the frame length
    assign gain = prod_reg[DIV_SHIFT +: VOL_W];

endmodule

// ----- sv/mvr_lane.sv -----
// one channel lane: gain multiply, shift, wrap and saturation
module mvr_lane
    import mvr_pkg::*;
(
    input  logic                       clk,
    input  pipe_ctl_t                  ctl,
    input  logic signed [SAMPLE_W-1:0] sample_in,
    input  logic [VOL_W-1:0]           gain,
    output logic signed [OUT_W-1:0]    sample_out
);

    logic signed [SAMPLE_W-1:0] s1_reg;
    logic signed [SAMPLE_W-1:0] s2_reg;
    logic signed [SCALE_W-1:0]  prod_reg;
    logic signed [SAMPLE_W-1:0] wrapped;

    // sample delay to meet the gain, then the product
    always_ff @(posedge clk)
    begin
        if (ctl.adv)
        begin
            s1_reg   <= sample_in;
            s2_reg   <= s1_reg;
            prod_reg <= SCALE_W'(s2_reg) * $signed({1'b0, gain});
        end
    end

    // arithmetic shift keeps the low 32 bits, then clamp
    always_comb
    begin
        wrapped = prod_reg[GAIN_SHIFT +: SAMPLE_W];
        if (wrapped > SAT_MAX)
        begin
            sample_out = SAT_MAX[OUT_W-1:0];
        end
        else if (wrapped < SAT_MIN)
        begin
            sample_out = SAT_MIN[OUT_W-1:0];
        end
        else
        begin
            sample_out = wrapped[OUT_W-1:0];
        end
    end

endmodule

// ----- sv/master_volume_ramp_output.sv -----
// top level: master volume ramp output stage of the mixer
//
// s_tdata carries one stereo word per accepted transfer: left and right
// 32-bit signed accumulated samples and the 16-bit target volume, which is
// only looked at on the first word of each 96-word frame. The gain ramps
// linearly from the previous frame's volume to the target and reaches it on
// the last word of the frame.
// m_tdata carries the two saturated 16-bit samples; m_tlast marks the last
// word of a frame. One result word leaves for every word taken in.
// m_tvalid rises once the word has passed every stage: it enters the ramp
// numerator register on the accepting edge, then the stage for the reciprocal
// divide by the frame length, the one for the per-lane gain multiply and the
// one for saturation into the output register.
// Throughput is one word per cycle while m_tready does not stall the
// pipeline; both lanes and the gain unit are fully pipelined.
// After reset the pipeline is empty, the frame position is zero and the
// previous volume is unity (0x8000).
// When the receiver holds m_tready low with a word waiting, the whole
// pipeline freezes and s_tready drops until that word is taken.
module master_volume_ramp_output
    import mvr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // left_in[31:0], right_in[63:32], target_volume[79:64]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // left_out[15:0], right_out[31:16]
    output logic        m_tlast
);

    pipe_ctl_t               ctl;
    logic                    item_last;
    logic [VOL_W-1:0]        gain;
    logic signed [OUT_W-1:0] left_lane;
    logic signed [OUT_W-1:0] right_lane;
    logic [2:0]              valid_reg;
    logic [2:0]              last_reg;
    logic                    out_valid_reg;
    logic                    out_last_reg;
    logic [31:0]             out_data_reg;

    // pipeline advance and acceptance
    assign ctl.adv   = !out_valid_reg || m_tready;
    assign ctl.take  = s_tvalid && ctl.adv;
    assign s_tready  = ctl.adv;

    // shared ramp gain
    mvr_gain u_gain (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .target_volume (s_tdata[79:64]),
        .item_last     (item_last),
        .gain          (gain)
    );

    // left and right lanes
    mvr_lane u_lane_left (
        .clk        (clk),
        .ctl        (ctl),
        .sample_in  ($signed(s_tdata[31:0])),
        .gain       (gain),
        .sample_out (left_lane)
    );

    mvr_lane u_lane_right (
        .clk        (clk),
        .ctl        (ctl),
        .sample_in  ($signed(s_tdata[63:32])),
        .gain       (gain),
        .sample_out (right_lane)
    );

    // word valid flags along the pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (ctl.adv)
        begin
            valid_reg     <= {valid_reg[1:0], ctl.take};
            out_valid_reg <= valid_reg[2];
        end
    end

    // frame end flags along the pipeline, and the lanes merged into the output word
    always_ff @(posedge clk)
    begin
        if (ctl.adv)
        begin
            last_reg     <= {last_reg[1:0], item_last};
            out_last_reg <= last_reg[2];
            out_data_reg <= {right_lane, left_lane};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule
